### hdl/pli_pkg.sv
// Shared types and constants for the plane/line intersection core.
// Used by every module of the block; depends on nothing else.
package pli_pkg;

  localparam int CW         = 32;               // coordinate width, Q16.16
  localparam int FRAC       = 16;               // fraction bits of every Q16.16 value
  localparam int CFGW       = 32;               // widest configuration register
  localparam int TOLW       = 16;               // tolerance register width
  localparam int DW         = CW + 35;          // den and num, 32 fraction bits
  localparam int PW         = CW + 1 + DW;      // |dir * num|
  localparam int QW         = CW + 2;           // quotient bits before saturation
  localparam int CHW        = 32;               // multiplier chunk width
  localparam int NCH        = (DW + CHW - 1) / CHW;
  localparam int REGW       = 3;                // register index width
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef logic signed [CW-1:0]   coord_t;
  typedef logic signed [CW:0]     dir_t;
  typedef logic signed [CFGW-1:0] creg_t;

  typedef enum logic [REGW-1:0] {
    REG_NORMAL_X = 3'd0,
    REG_NORMAL_Y = 3'd1,
    REG_NORMAL_Z = 3'd2,
    REG_OFFSET   = 3'd3,
    REG_ZERO_TOL = 3'd4,
    REG_UNIT_TOL = 3'd5
  } reg_idx_e;

  typedef struct packed {
    creg_t [2:0]     normal;
    creg_t           offset;
    logic [TOLW-1:0] zero_tol;
    logic [TOLW-1:0] unit_tol;
  } cfg_t;

  // Classified query handed from the front end to the back end.
  typedef struct packed {
    logic                  hit;
    coord_t [2:0]          pa;
    dir_t [2:0]            dir;
    logic signed [DW-1:0]  num;      // numerator, sign already folded with den
    logic [DW-1:0]         absden;
  } mid_t;

  typedef struct packed {
    logic         hit;
    coord_t [2:0] pt;
  } res_t;

endpackage

### hdl/pli_front.sv
// Front end: takes query words, forms direction, dot products and the hit test.
// Depends on pli_pkg.
module pli_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pli_pkg::cfg_t       cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                command_i,
  input  pli_pkg::coord_t [2:0] point_a_i,
  input  pli_pkg::coord_t [2:0] point_b_i,
  output logic                mid_valid_o,
  input  logic                mid_ready_i,
  output pli_pkg::mid_t       mid_o
);
  import pli_pkg::*;

  localparam int NS  = 6;
  localparam int PAW = CFGW + CW;
  localparam int PDW = CFGW + CW + 1;
  localparam int UBW = DW + TOLW;
  localparam int LW  = UBW + 2;

  typedef struct packed {
    logic         seg;
    coord_t [2:0] a;
    dir_t [2:0]   dir;
  } geo_t;

  logic                 en;
  logic [NS-1:0]        v_q;
  geo_t                 geo_d;
  geo_t                 geo_q [NS-1];
  logic signed [PAW-1:0] pna_d [3];
  logic signed [PAW-1:0] pna_q [3];
  logic signed [PDW-1:0] pnd_d [3];
  logic signed [PDW-1:0] pnd_q [3];
  logic signed [DW-1:0] den3_d, den3_q, num3_d, num3_q;
  logic signed [DW-1:0] num4_d, num4_q, num5_q;
  logic [DW-1:0]        absden4_d, absden4_q, absden5_q;
  logic                 par4_d, par4_q, par5_q;
  logic [UBW-1:0]       ub5_d, ub5_q;
  logic signed [LW-1:0] lhs, ubs, hbs;
  logic                 hit6_d;
  mid_t                 mid_q;

  assign en          = ~v_q[NS-1] | mid_ready_i;
  assign in_ready_o  = en;
  assign mid_valid_o = v_q[NS-1];
  assign mid_o       = mid_q;

  always_comb begin
    geo_d.seg = command_i;
    for (int i = 0; i < 3; i++) begin
      geo_d.a[i] = point_a_i[i];
      if (command_i) begin
        geo_d.dir[i] = {point_a_i[i][CW-1], point_a_i[i]} - {point_b_i[i][CW-1], point_b_i[i]};
      end else begin
        geo_d.dir[i] = {point_b_i[i][CW-1], point_b_i[i]};
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pna_d[i] = $signed(cfg_i.normal[i]) * $signed(geo_q[0].a[i]);
      pnd_d[i] = $signed(cfg_i.normal[i]) * $signed(geo_q[0].dir[i]);
    end
  end

  // The offset d is Q16.16 while the dot products carry 32 fraction bits.
  assign den3_d = pnd_q[0] + pnd_q[1] + pnd_q[2];
  assign num3_d = pna_q[0] + pna_q[1] + pna_q[2] - $signed({cfg_i.offset, {FRAC{1'b0}}});

  // Fold the sign of den into num so the bounds compare against |den|.
  assign absden4_d = den3_q[DW-1] ? DW'(-den3_q) : den3_q;
  assign num4_d    = den3_q[DW-1] ? -num3_q : num3_q;
  assign par4_d    = absden4_d <= DW'({cfg_i.zero_tol, {FRAC{1'b0}}});

  assign ub5_d = absden4_q * cfg_i.unit_tol;

  assign lhs = $signed({{2{num5_q[DW-1]}}, num5_q, {FRAC{1'b0}}});
  assign ubs = $signed({2'b00, ub5_q});
  assign hbs = $signed({2'b00, absden5_q, {FRAC{1'b0}}}) + ubs;

  always_comb begin
    if (par5_q) begin
      hit6_d = 1'b0;
    end else if (geo_q[4].seg) begin
      hit6_d = ~((lhs < -ubs) | (lhs > hbs));
    end else begin
      hit6_d = ~(lhs > ubs);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NS-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      geo_q[0] <= geo_d;
      for (int s = 1; s < NS - 1; s++) begin
        geo_q[s] <= geo_q[s-1];
      end
      pna_q     <= pna_d;
      pnd_q     <= pnd_d;
      den3_q    <= den3_d;
      num3_q    <= num3_d;
      num4_q    <= num4_d;
      absden4_q <= absden4_d;
      par4_q    <= par4_d;
      num5_q    <= num4_q;
      absden5_q <= absden4_q;
      par5_q    <= par4_q;
      ub5_q     <= ub5_d;
      mid_q.hit    <= hit6_d;
      mid_q.pa     <= geo_q[4].a;
      mid_q.dir    <= geo_q[4].dir;
      mid_q.num    <= num5_q;
      mid_q.absden <= absden5_q;
    end
  end

endmodule

### hdl/pli_queue.sv
// Short queue of classified queries between the front end and the back end.
// Depends on pli_pkg.
module pli_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pli_pkg::mid_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output pli_pkg::mid_t data_o
);
  import pli_pkg::*;

  mid_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, rd_q;
  logic [FIFO_AW:0]   cnt_q;
  logic               do_push, do_pop;

  assign full_o  = cnt_q == (FIFO_AW + 1)'(FIFO_DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (FIFO_AW + 1)'(do_push) - (FIFO_AW + 1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

### hdl/pli_back.sv
// Back end: hit point a - dir*num/|den| with a pipelined restoring divider,
// saturation and the result queue. Depends on pli_pkg.
module pli_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          mid_valid_i,
  output logic          mid_ready_o,
  input  pli_pkg::mid_t mid_i,
  output logic          empty_o,
  input  logic          pop_i,
  output pli_pkg::res_t res_o
);
  import pli_pkg::*;

  localparam int NB  = QW + 5;
  localparam int PPW = CW + 1 + CHW;
  localparam int HW  = CW + 4;

  typedef struct packed {
    logic         hit;
    coord_t [2:0] pa;
    logic [2:0]   pneg;
  } tag_t;

  typedef struct packed {
    tag_t                  tag;
    logic [2:0]            big;
    logic [DW:0]           dvs;
    logic [2:0][DW:0]      rem;
    logic [2:0][QW-1:0]    lo;
  } dst_t;

  logic                         en;
  logic [NB-1:0]                v_q;
  tag_t                         tag_d;
  tag_t                         tag_q [4];
  logic [DW-1:0]                absden_q [3];
  logic [2:0][CW:0]             absdir_d, absdir1_q;
  logic [NCH*CHW-1:0]           absnum_d, absnum1_q;
  logic [2:0][NCH-1:0][PPW-1:0] pp_d, pp2_q;
  logic [2:0][PW-1:0]           absp_d, absp3_q;
  logic [2:0][PW:0]             dvd_d, dvd4_q;
  logic [DW:0]                  dvs4_q;
  dst_t                         d_d [QW+1];
  dst_t                         d_q [QW+1];
  logic [DW+1:0]                step_t [QW][3];
  logic                         step_ge [QW][3];
  logic signed [HW-1:0]         hsum [3];
  res_t                         res_d;
  logic                         oq_full, oq_push, oq_pop;
  res_t                         oq_mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]           oq_wr_q, oq_rd_q;
  logic [FIFO_AW:0]             oq_cnt_q;

  assign en          = ~v_q[NB-1] | ~oq_full;
  assign mid_ready_o = en;

  // Magnitudes and product sign.
  always_comb begin
    tag_d.hit = mid_i.hit;
    tag_d.pa  = mid_i.pa;
    absnum_d  = (NCH * CHW)'(mid_i.num[DW-1] ? DW'(-mid_i.num) : DW'(mid_i.num));
    for (int i = 0; i < 3; i++) begin
      tag_d.pneg[i] = mid_i.dir[i][CW] ^ mid_i.num[DW-1];
      absdir_d[i]   = mid_i.dir[i][CW] ? (CW + 1)'(-mid_i.dir[i]) : (CW + 1)'(mid_i.dir[i]);
    end
  end

  // The wide numerator is split into chunks so each multiplier stays narrow.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < NCH; k++) begin
        pp_d[i][k] = absdir1_q[i] * absnum1_q[k*CHW +: CHW];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      absp_d[i] = '0;
      for (int k = 0; k < NCH; k++) begin
        absp_d[i] = absp_d[i] + (PW'(pp2_q[i][k]) << (k * CHW));
      end
    end
  end

  // Round to nearest, ties away from zero: (2|p| + |den|) / (2|den|).
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dvd_d[i] = {absp3_q[i], 1'b0} + (PW + 1)'(absden_q[2]);
    end
  end

  // Quotients of 2^QW or more saturate, so the divider only needs QW steps.
  always_comb begin
    d_d[0].tag = tag_q[3];
    d_d[0].dvs = dvs4_q;
    for (int i = 0; i < 3; i++) begin
      d_d[0].big[i] = {1'b0, dvd4_q[i][PW:QW]} >= dvs4_q;
      d_d[0].rem[i] = {1'b0, dvd4_q[i][PW:QW]};
      d_d[0].lo[i]  = dvd4_q[i][QW-1:0];
    end
    for (int s = 0; s < QW; s++) begin
      d_d[s+1].tag = d_q[s].tag;
      d_d[s+1].big = d_q[s].big;
      d_d[s+1].dvs = d_q[s].dvs;
      for (int i = 0; i < 3; i++) begin
        step_t[s][i]     = {d_q[s].rem[i], d_q[s].lo[i][QW-1]};
        step_ge[s][i]    = step_t[s][i] >= {1'b0, d_q[s].dvs};
        d_d[s+1].rem[i]  = step_ge[s][i] ? (DW + 1)'(step_t[s][i] - {1'b0, d_q[s].dvs})
                                         : (DW + 1)'(step_t[s][i]);
        d_d[s+1].lo[i]   = {d_q[s].lo[i][QW-2:0], step_ge[s][i]};
      end
    end
  end

  // Apply the offset to the origin and clamp to the coordinate range; a miss gives zero.
  always_comb begin
    res_d.hit = d_q[QW].tag.hit;
    for (int i = 0; i < 3; i++) begin
      if (d_q[QW].tag.pneg[i]) begin
        hsum[i] = $signed({{4{d_q[QW].tag.pa[i][CW-1]}}, d_q[QW].tag.pa[i]})
                + $signed({2'b00, d_q[QW].lo[i]});
      end else begin
        hsum[i] = $signed({{4{d_q[QW].tag.pa[i][CW-1]}}, d_q[QW].tag.pa[i]})
                - $signed({2'b00, d_q[QW].lo[i]});
      end
      if (!d_q[QW].tag.hit) begin
        res_d.pt[i] = '0;
      end else if (d_q[QW].big[i]) begin
        res_d.pt[i] = d_q[QW].tag.pneg[i] ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
      end else if (hsum[i][HW-1:CW-1] == {(HW-CW+1){hsum[i][HW-1]}}) begin
        res_d.pt[i] = hsum[i][CW-1:0];
      end else begin
        res_d.pt[i] = hsum[i][HW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NB-2:0], mid_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tag_q[0]    <= tag_d;
      tag_q[1]    <= tag_q[0];
      tag_q[2]    <= tag_q[1];
      tag_q[3]    <= tag_q[2];
      absden_q[0] <= mid_i.absden;
      absden_q[1] <= absden_q[0];
      absden_q[2] <= absden_q[1];
      absdir1_q   <= absdir_d;
      absnum1_q   <= absnum_d;
      pp2_q       <= pp_d;
      absp3_q     <= absp_d;
      dvd4_q      <= dvd_d;
      dvs4_q      <= {absden_q[2], 1'b0};
      for (int s = 0; s <= QW; s++) begin
        d_q[s] <= d_d[s];
      end
    end
  end

  // Result queue.
  assign oq_full = oq_cnt_q == (FIFO_AW + 1)'(FIFO_DEPTH);
  assign empty_o = oq_cnt_q == '0;
  assign oq_push = v_q[NB-1] & ~oq_full;
  assign oq_pop  = pop_i & ~empty_o;
  assign res_o   = oq_mem_q[oq_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      if (oq_push) begin
        oq_wr_q <= (oq_wr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : oq_wr_q + 1'b1;
      end
      if (oq_pop) begin
        oq_rd_q <= (oq_rd_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : oq_rd_q + 1'b1;
      end
      oq_cnt_q <= oq_cnt_q + (FIFO_AW + 1)'(oq_push) - (FIFO_AW + 1)'(oq_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (oq_push) begin
      oq_mem_q[oq_wr_q] <= res_d;
    end
  end

endmodule

### hdl/plane_line_intersection_core.sv
// Top level of the plane/line intersection core: configuration registers and
// the front end, middle queue and back end. Depends on pli_pkg, pli_front,
// pli_queue and pli_back.
//
//   channel   handshake            payload
//   -------   ------------------   ---------------------------------------------
//   query     push / full          command_i, point_a_{x,y,z}_i, point_b_{x,y,z}_i
//   result    pop / empty          hit_o, hit_{x,y,z}_o
//
//   config    cfg_we_i             cfg_idx_i, cfg_wdata_i
//
// One query word is taken per cycle while full is low, and one result word leaves per cycle while empty is low.
// The delay from an accepted query word until empty falls is set mostly by the divider,
// which resolves one quotient bit per stage.
// Reset clears all valid bits and queue pointers; no clearing pass is needed.
// When pop stays low the result queue fills, the back end halts, the middle
// queue fills behind it and full rises; each side stalls only on its own queue.
module plane_line_intersection_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [pli_pkg::REGW-1:0]    cfg_idx_i,
  input  logic [pli_pkg::CFGW-1:0]    cfg_wdata_i,
  input  logic                        push,
  output logic                        full,
  input  logic                        command_i,
  input  pli_pkg::coord_t             point_a_x_i,
  input  pli_pkg::coord_t             point_a_y_i,
  input  pli_pkg::coord_t             point_a_z_i,
  input  pli_pkg::coord_t             point_b_x_i,
  input  pli_pkg::coord_t             point_b_y_i,
  input  pli_pkg::coord_t             point_b_z_i,
  input  logic                        pop,
  output logic                        empty,
  output logic                        hit_o,
  output pli_pkg::coord_t             hit_x_o,
  output pli_pkg::coord_t             hit_y_o,
  output pli_pkg::coord_t             hit_z_o
);
  import pli_pkg::*;

  localparam creg_t           NORMAL_Z_RST = creg_t'(1 << FRAC);
  localparam logic [TOLW-1:0] ZERO_TOL_RST = TOLW'(1);
  localparam logic [TOLW-1:0] UNIT_TOL_RST = TOLW'(66);

  cfg_t         cfg_q;
  logic         front_ready, mid_valid, mid_full, mid_empty, back_ready;
  mid_t         front_mid, queue_mid;
  res_t         res;
  coord_t [2:0] pa, pb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.normal[0] <= '0;
      cfg_q.normal[1] <= '0;
      cfg_q.normal[2] <= NORMAL_Z_RST;
      cfg_q.offset    <= '0;
      cfg_q.zero_tol  <= ZERO_TOL_RST;
      cfg_q.unit_tol  <= UNIT_TOL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_NORMAL_X: cfg_q.normal[0] <= cfg_wdata_i;
        REG_NORMAL_Y: cfg_q.normal[1] <= cfg_wdata_i;
        REG_NORMAL_Z: cfg_q.normal[2] <= cfg_wdata_i;
        REG_OFFSET:   cfg_q.offset    <= cfg_wdata_i;
        REG_ZERO_TOL: cfg_q.zero_tol  <= cfg_wdata_i[TOLW-1:0];
        REG_UNIT_TOL: cfg_q.unit_tol  <= cfg_wdata_i[TOLW-1:0];
        default: ;
      endcase
    end
  end

  assign pa   = {point_a_z_i, point_a_y_i, point_a_x_i};
  assign pb   = {point_b_z_i, point_b_y_i, point_b_x_i};
  assign full = ~front_ready;

  pli_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (push),
    .in_ready_o  (front_ready),
    .command_i   (command_i),
    .point_a_i   (pa),
    .point_b_i   (pb),
    .mid_valid_o (mid_valid),
    .mid_ready_i (~mid_full),
    .mid_o       (front_mid)
  );

  pli_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_valid),
    .data_i  (front_mid),
    .full_o  (mid_full),
    .pop_i   (back_ready),
    .empty_o (mid_empty),
    .data_o  (queue_mid)
  );

  pli_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_valid_i (~mid_empty),
    .mid_ready_o (back_ready),
    .mid_i       (queue_mid),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (res)
  );

  assign hit_o   = res.hit;
  assign hit_x_o = res.pt[0];
  assign hit_y_o = res.pt[1];
  assign hit_z_o = res.pt[2];

endmodule

### hdl/pli_checker.sv
// Port-level checks for the plane/line intersection core, bound to the top level.
// Depends on pli_pkg and plane_line_intersection_core.
module pli_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            push,
  input logic            full,
  input logic            pop,
  input logic            empty,
  input logic            hit_o,
  input pli_pkg::coord_t hit_x_o,
  input pli_pkg::coord_t hit_y_o,
  input pli_pkg::coord_t hit_z_o
);
  import pli_pkg::*;

  // Words accepted on the query side and not yet taken on the result side.
  logic [7:0] inflight_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + 8'(push & ~full) - 8'(pop & ~empty);
    end
  end

  a_no_result_without_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty) |-> (inflight_q != 8'd0))
    else $error("result word delivered with no query outstanding");

  a_miss_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !hit_o) |-> (hit_x_o == '0 && hit_y_o == '0 && hit_z_o == '0))
    else $error("miss result carries a nonzero point");

  // Once reset has been seen at an edge, the queues read as clear at the next one.
  a_reset_state: assert property (@(posedge clk_i)
    !rst_ni |=> (empty && !full))
    else $error("queues not clear during reset");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(hit_o) && $stable(hit_x_o)
                          && $stable(hit_y_o) && $stable(hit_z_o)))
    else $error("waiting result word changed before it was taken");

endmodule

bind plane_line_intersection_core pli_checker u_pli_checker (.*);
